[src/dft_pkg.sv]
// Shared types, constants and the CRC step for the DLE frame transmitter.
`timescale 1ns / 1ps

package dft_pkg;

  // Framing bytes and CRC16-XMODEM constants.
  localparam logic [7:0]  DLE_BYTE = 8'h10;
  localparam logic [7:0]  STX_BYTE = 8'h02;
  localparam logic [7:0]  ETX_BYTE = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  CHUNK_SIZE_RST = 8'd20;

  // One input item can cause at most this many output bytes.
  localparam int RUN_MAX = 10;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  // Input item: one byte of a command frame.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       starts_frame;
    logic       ends_frame;
  } in_item_t;

  // Result item: one byte of the framed, stuffed stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       chunk_end;
    logic       frame_done;
  } out_item_t;

  // All output bytes caused by one input item, entry 0 goes out first.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    starts;
    logic                    ends;
  } run_t;

  // CRC16-XMODEM update by one byte, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/dft_builder.sv]
// Frame builder: keeps CRC, sequence and frame state and expands one item into its output bytes.
`timescale 1ns / 1ps

module dft_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  dft_pkg::in_item_t in_data,
  input  logic              in_fire,
  output dft_pkg::run_t     run,
  output logic              run_vld
);
  import dft_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic        open_r, open_nxt;

  // Build the list of output bytes and the next frame state.
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [15:0]      c;
    logic [7:0]       b;
    cnt      = '0;
    c        = crc_r;
    b        = in_data.in_byte;
    run      = '0;
    run_vld  = 1'b0;
    seq_nxt  = seq_r;
    open_nxt = open_r;
    if (in_data.starts_frame) begin
      run_vld = 1'b1;
      run.bytes[cnt] = DLE_BYTE;
      cnt = cnt + 1'b1;
      run.bytes[cnt] = STX_BYTE;
      cnt = cnt + 1'b1;
      run.bytes[cnt] = b;
      cnt = cnt + 1'b1;
      if (b == DLE_BYTE) begin
        run.bytes[cnt] = b;
        cnt = cnt + 1'b1;
      end
      run.bytes[cnt] = seq_r;
      cnt = cnt + 1'b1;
      if (seq_r == DLE_BYTE) begin
        run.bytes[cnt] = seq_r;
        cnt = cnt + 1'b1;
      end
      c        = crc_step(crc_step(16'h0000, b), seq_r);
      seq_nxt  = seq_r + 8'd1;
      open_nxt = 1'b1;
    end else if (open_r) begin
      run_vld = 1'b1;
      run.bytes[cnt] = b;
      cnt = cnt + 1'b1;
      if (b == DLE_BYTE) begin
        run.bytes[cnt] = b;
        cnt = cnt + 1'b1;
      end
      c = crc_step(crc_r, b);
    end
    // The CRC goes out unstuffed, then the trailer.
    if (run_vld && in_data.ends_frame) begin
      run.bytes[cnt] = c[15:8];
      cnt = cnt + 1'b1;
      run.bytes[cnt] = c[7:0];
      cnt = cnt + 1'b1;
      run.bytes[cnt] = DLE_BYTE;
      cnt = cnt + 1'b1;
      run.bytes[cnt] = ETX_BYTE;
      cnt = cnt + 1'b1;
      open_nxt = 1'b0;
    end
    run.cnt    = cnt;
    run.starts = in_data.starts_frame;
    run.ends   = in_data.ends_frame;
    crc_nxt    = c;
  end

  // Frame state advances when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      seq_r  <= '0;
      open_r <= 1'b0;
    end else if (in_fire) begin
      crc_r  <= crc_nxt;
      seq_r  <= seq_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

[src/dft_emitter.sv]
// Byte emitter: holds one item's bytes, sends one per cycle unless stalled and marks chunk boundaries.
`timescale 1ns / 1ps

module dft_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         chunk_size,
  input  dft_pkg::run_t      run_in,
  input  logic               load,
  output logic               run_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dft_pkg::out_item_t out_data
);
  import dft_pkg::*;

  run_t      run_r, run_shift;
  logic      run_vld_r;
  out_item_t out_r, out_nxt;
  logic      out_vld_r;
  logic [7:0] fill_r, fill_nxt;
  logic       emit, last;
  logic [8:0] limit, fill1;
  logic       close, frame_end;

  assign emit      = run_vld_r && (!out_vld_r || out_ready);
  assign last      = (run_r.cnt == CNT_W'(1));
  assign run_ready = !run_vld_r || (emit && last);

  // Chunk accounting; a frame always opens a new chunk.
  always_comb begin
    logic [7:0] base;
    base      = run_r.starts ? 8'd0 : fill_r;
    limit     = {(chunk_size == 8'd0), chunk_size};
    fill1     = {1'b0, base} + 9'd1;
    frame_end = last && run_r.ends;
    close     = frame_end || (fill1 >= limit);
    fill_nxt  = close ? 8'd0 : fill1[7:0];
    out_nxt.out_byte   = run_r.bytes[0];
    out_nxt.run_last   = last;
    out_nxt.chunk_end  = close;
    out_nxt.frame_done = frame_end;
  end

  // Remaining bytes move down one place per sent byte.
  always_comb begin
    run_shift        = run_r;
    run_shift.bytes  = {8'h00, run_r.bytes[RUN_MAX-1:1]};
    run_shift.cnt    = run_r.cnt - 1'b1;
    run_shift.starts = 1'b0;
  end

  // Run buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_vld_r <= 1'b0;
    end else if (load) begin
      run_vld_r <= 1'b1;
    end else if (emit) begin
      run_vld_r <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_in;
    end else if (emit) begin
      run_r <= run_shift;
    end
  end

  // Output register and chunk fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      fill_r    <= '0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
      fill_r    <= fill_nxt;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A held run always has between one and the maximum number of bytes.
  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    run_vld_r |-> (run_r.cnt != '0) && (run_r.cnt <= CNT_W'(RUN_MAX)))
    else $error("run buffer byte count out of range");

  // The trailer byte closes the chunk and ends its item's run.
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.frame_done |-> out_r.chunk_end && out_r.run_last)
    else $error("frame end without chunk end or run end");

  // A run is not dropped before its last byte has been sent.
  a_run_keep: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !last |=> run_vld_r)
    else $error("run buffer emptied early");

endmodule

[src/dle_frame_transmitter_crc16.sv]
// Top level of the DLE frame transmitter with CRC16-XMODEM.
`timescale 1ns / 1ps

// Takes command frames one byte per item and sends them as 0x10 0x02, opcode,
// sequence number, payload, CRC16-XMODEM high and low byte, 0x10 0x03, with
// every 0x10 in opcode, sequence number and payload doubled. Results come out
// one byte per cycle, unless out_ready stalls them, from a single output
// register. An item causes one or two bytes for a payload byte, up to six for
// an opcode, and four more when the frame ends at that byte, so up to ten for an
// opcode that also ends its frame; a byte outside a frame causes none. The
// next item is accepted while the last byte of the current one moves to the
// output register. chunk_size resets to 20, and 0 means 256. The user must
// write it via cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module dle_frame_transmitter_crc16 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dft_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import dft_pkg::*;

  logic [7:0] chunk_size_r;
  logic       in_fire;
  run_t       run;
  logic       run_vld;
  logic       run_ready;

  // Chunk size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_size_r <= CHUNK_SIZE_RST;
    end else if (cfg_we) begin
      chunk_size_r <= cfg_wdata;
    end
  end

  // An item is taken when the run buffer is free or frees this cycle.
  assign in_ready = run_ready;
  assign in_fire  = in_valid && run_ready;

  dft_builder u_builder (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .in_fire (in_fire),
    .run     (run),
    .run_vld (run_vld)
  );

  dft_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .chunk_size (chunk_size_r),
    .run_in     (run),
    .load       (in_fire && run_vld),
    .run_ready  (run_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the DLE frame transmitter with stuffing, CRC16 and chunk marks.
`timescale 1ns / 1ps

module tb_top;
  import dft_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // Clock, reset and block inputs, all known from time zero.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // Idle percentages for the sending and the receiving side.
  int gap_pct   = 30;
  int stall_pct = 30;
  int fail_count = 0;
  int idle_cycles = 0;

  // Predictor state: a copy of the block's registers and the expected output bytes.
  logic [7:0]  chunk_len;
  logic [15:0] crc_acc;
  logic [7:0]  seq_num;
  logic [7:0]  chunk_fill_m;
  bit          frame_is_open;
  out_item_t   expected_bytes[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  dle_frame_transmitter_crc16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // CRC16-XMODEM over one byte, one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Appends one output byte and keeps track of the chunk fill.
  function automatic void emit_byte(ref out_item_t q[$], input logic [7:0] b,
                                    input bit frame_last);
    int        lim;
    int        fill;
    bit        close;
    out_item_t r;
    lim = (chunk_len == 8'd0) ? 256 : int'(chunk_len);
    fill = int'(chunk_fill_m) + 1;
    close = frame_last || (fill >= lim);
    chunk_fill_m = close ? 8'd0 : 8'(fill);
    r.out_byte = b;
    r.run_last = 1'b0;
    r.chunk_end = close;
    r.frame_done = frame_last;
    q.push_back(r);
  endfunction

  // A byte covered by the CRC; a DLE byte goes out twice.
  function automatic void emit_covered(ref out_item_t q[$], input logic [7:0] b);
    crc_acc = crc16_xmodem_byte(crc_acc, b);
    emit_byte(q, b, 1'b0);
    if (b == DLE_BYTE) begin
      emit_byte(q, b, 1'b0);
    end
  endfunction

  // Works out the stuffed output bytes that one accepted item causes.
  function automatic void predict_frame_bytes(input in_item_t it);
    out_item_t run_q[$];
    out_item_t tail;
    if (it.starts_frame) begin
      // A start abandons any open frame and opens a new one.
      frame_is_open = 1'b1;
      crc_acc = '0;
      chunk_fill_m = '0;
      emit_byte(run_q, DLE_BYTE, 1'b0);
      emit_byte(run_q, STX_BYTE, 1'b0);
      emit_covered(run_q, it.in_byte);
      emit_covered(run_q, seq_num);
      seq_num = seq_num + 8'd1;
    end else if (frame_is_open) begin
      emit_covered(run_q, it.in_byte);
    end else begin
      // Bytes outside a frame are dropped.
      return;
    end
    if (it.ends_frame) begin
      emit_byte(run_q, crc_acc[15:8], 1'b0);
      emit_byte(run_q, crc_acc[7:0], 1'b0);
      emit_byte(run_q, DLE_BYTE, 1'b0);
      emit_byte(run_q, ETX_BYTE, 1'b1);
      frame_is_open = 1'b0;
    end
    tail = run_q.pop_back();
    tail.run_last = 1'b1;
    run_q.push_back(tail);
    foreach (run_q[i]) begin
      expected_bytes.push_back(run_q[i]);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Predicts on each accepted input item and checks each accepted result item.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      chunk_len = CHUNK_SIZE_RST;
      crc_acc = '0;
      seq_num = '0;
      chunk_fill_m = '0;
      frame_is_open = 1'b0;
    end else begin
      if (cfg_we) begin
        chunk_len = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_frame_bytes(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("result item with none expected: out_byte %0h", out_data.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("run_last", want.run_last, out_data.run_last);
          check_field("chunk_end", want.chunk_end, out_data.chunk_end);
          check_field("frame_done", want.frame_done, out_data.frame_done);
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item after a random gap and returns at the edge that accepts it.
  task automatic send_item(input logic [7:0] b, input bit sof, input bit eof);
    in_item_t it;
    it.in_byte = b;
    it.starts_frame = sof;
    it.ends_frame = eof;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Waits until every expected byte has come, then lets the block settle.
  task automatic wait_drained();
    @(negedge clk);
    while (expected_bytes.size() != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chunk_size(input logic [7:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 3) == 0) ? DLE_BYTE : 8'($urandom_range(0, 255));
  endfunction

  // Dropped bytes, extreme byte values, empty frames and a restart inside a frame.
  task automatic test_directed_frames();
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(DLE_BYTE, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(DLE_BYTE, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(DLE_BYTE, 1'b1, 1'b0);
    send_item(DLE_BYTE, 1'b0, 1'b0);
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(DLE_BYTE, 1'b0, 1'b1);
  endtask

  // Chunk marks at the smallest size, and a size lowered below the open chunk's fill.
  task automatic test_chunk_boundaries();
    write_chunk_size(8'd1);
    send_item(DLE_BYTE, 1'b1, 1'b0);
    send_item(DLE_BYTE, 1'b0, 1'b1);
    write_chunk_size(8'd255);
    send_item(8'h21, 1'b1, 1'b0);
    send_item(8'h33, 1'b0, 1'b0);
    write_chunk_size(8'd3);
    send_item(8'h44, 1'b0, 1'b1);
  endtask

  // Mostly well-formed frames with random content, some stray and broken items.
  task automatic test_random_frames(input int n_items, input int gap, input int stall);
    int  sent;
    int  len;
    bit  tx_open;
    bit  sof;
    bit  eof;
    sent = 0;
    tx_open = 1'b0;
    gap_pct = gap;
    stall_pct = stall;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        sof = 1'($urandom_range(0, 1));
        eof = 1'($urandom_range(0, 1));
        send_item(rand_byte(), sof, eof);
        if (sof || tx_open) begin
          sent++;
          tx_open = !eof;
        end
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) : $urandom_range(6, 60);
        send_item(rand_byte(), 1'b1, len == 0);
        sent++;
        for (int k = 1; k <= len; k++) begin
          send_item(rand_byte(), 1'b0, k == len);
          sent++;
        end
        tx_open = 1'b0;
      end
    end
    gap_pct = 30;
    stall_pct = 30;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_chunk_boundaries();
    write_chunk_size(8'd20);
    test_random_frames(160, 30, 30);
    // A long stretch with both sides always ready.
    write_chunk_size(8'd1);
    test_random_frames(80, 0, 0);
    write_chunk_size(8'd255);
    test_random_frames(120, 30, 30);
    write_chunk_size(8'($urandom_range(2, 16)));
    test_random_frames(120, 30, 30);
    in_valid <= 1'b0;
    wait_drained();
    if (expected_bytes.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
src/dft_pkg.sv
src/dft_builder.sv
src/dft_emitter.sv
src/dle_frame_transmitter_crc16.sv
dv/tb_top.sv
